@@ hdl/plob_pkg.sv @@
`timescale 1ns / 1ps
package plob_pkg;

   localparam int CSR_W        = 4;
   localparam int ROW_LEVEL_W  = 4;
   localparam int ROW_AMOUNT_W = 42;
   localparam int ROW_ORDERS_W = 11;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_MODIFY = 2'd2,
      ACT_TRADE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OUT_OK       = 2'd0,
      OUT_NOTFOUND = 2'd1,
      OUT_FULL     = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_REMOVE,
      OP_INSERT
   } level_op_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] seq;
      logic [9:0]  book_id;
      logic        side;
      logic [31:0] price;
      logic [31:0] amount;
   } req_item_type;

   typedef struct packed {
      logic [31:0]               echo_seq;
      logic [31:0]               traded_price;
      logic [63:0]               traded_volume;
      logic                      aggressor;
      logic [1:0]                outcome;
      logic                      row_side;
      logic [ROW_LEVEL_W-1:0]    row_level;
      logic [31:0]               row_price;
      logic [ROW_AMOUNT_W-1:0]   row_amount;
      logic [ROW_ORDERS_W-1:0]   row_orders;
      logic                      last_row;
   } rsp_item_type;

   // one order table entry
   typedef struct packed {
      logic        live;
      logic        on_ask;
      logic [31:0] price;
      logic [31:0] qty;
   } order_entry_type;

   // command broadcast along one side's chain of level cells
   typedef struct packed {
      level_op_type op;
      logic [31:0]  price;
      logic [31:0]  amount;
   } level_cmd_type;

   typedef struct packed {
      logic found;
      logic full;
   } level_stat_type;

endpackage

@@ hdl/plob_ram.sv @@
`timescale 1ns / 1ps
module plob_ram #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/plob_cell.sv @@
`timescale 1ns / 1ps
module plob_cell
   import plob_pkg::*;
#(
   parameter int QTY_W      = 42,
   parameter int CNT_W      = 11,
   parameter bit DESCENDING = 1'b1
) (
   input  logic              clock,
   input  level_cmd_type     cmd,
   input  logic              valid_i,
   input  logic              found_i,
   input  logic              full_i,
   input  logic              drain_i,
   input  logic              at_prev_i,
   input  logic [31:0]       prev_price,
   input  logic [QTY_W-1:0]  prev_qty,
   input  logic [CNT_W-1:0]  prev_cnt,
   input  logic [31:0]       next_price,
   input  logic [QTY_W-1:0]  next_qty,
   input  logic [CNT_W-1:0]  next_cnt,
   output logic [31:0]       price_o,
   output logic [QTY_W-1:0]  qty_o,
   output logic [CNT_W-1:0]  cnt_o,
   output logic              eq_o,
   output logic              at_o,
   output logic              drain_o
);

   logic [31:0]      price_ff, price_in;
   logic [QTY_W-1:0] qty_ff, qty_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             better;
   logic [QTY_W-1:0] amt_ext;

   assign amt_ext = QTY_W'(cmd.amount);
   assign better  = DESCENDING ? (cmd.price > price_ff) : (cmd.price < price_ff);
   assign eq_o    = valid_i && (price_ff == cmd.price);
   // key belongs at or before this cell
   assign at_o    = valid_i ? (eq_o || better) : 1'b1;
   assign drain_o = (cmd.op == OP_REMOVE) && eq_o && (cnt_ff <= CNT_W'(1));

   always_comb begin
      price_in = price_ff;
      qty_in   = qty_ff;
      cnt_in   = cnt_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (found_i) begin
               if (eq_o) begin
                  qty_in = qty_ff + amt_ext;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end else if (!full_i) begin
               if (at_prev_i) begin
                  price_in = prev_price;
                  qty_in   = prev_qty;
                  cnt_in   = prev_cnt;
               end else if (at_o) begin
                  price_in = cmd.price;
                  qty_in   = amt_ext;
                  cnt_in   = CNT_W'(1);
               end
            end
         end
         OP_REMOVE: begin
            if (found_i) begin
               if (drain_i) begin
                  if (at_o) begin
                     price_in = next_price;
                     qty_in   = next_qty;
                     cnt_in   = next_cnt;
                  end
               end else if (eq_o) begin
                  qty_in = (qty_ff >= amt_ext) ? qty_ff - amt_ext : '0;
                  cnt_in = (cnt_ff != '0) ? cnt_ff - CNT_W'(1) : '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      qty_ff   <= qty_in;
      cnt_ff   <= cnt_in;
   end

   assign price_o = price_ff;
   assign qty_o   = qty_ff;
   assign cnt_o   = cnt_ff;

endmodule

@@ hdl/plob_side.sv @@
`timescale 1ns / 1ps
module plob_side
   import plob_pkg::*;
#(
   parameter int LEVELS     = 16,
   parameter int QTY_W      = 42,
   parameter int CNT_W      = 11,
   parameter bit DESCENDING = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  level_cmd_type          cmd,
   output level_stat_type         stat,
   input  logic [ROW_LEVEL_W-1:0] row_idx,
   output logic                   row_valid,
   output logic [31:0]            row_price,
   output logic [QTY_W-1:0]       row_qty,
   output logic [CNT_W-1:0]       row_cnt
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int USED_W = $clog2(LEVELS + 1);
   localparam int RW     = (USED_W > ROW_LEVEL_W) ? USED_W : ROW_LEVEL_W;

   logic [USED_W-1:0] used_ff, used_in;
   logic [31:0]       price_a [LEVELS];
   logic [QTY_W-1:0]  qty_a   [LEVELS];
   logic [CNT_W-1:0]  cnt_a   [LEVELS];
   logic [LEVELS-1:0] eq_v, at_v, drain_v, valid_v;
   logic              found, full, drain;
   logic [RW-1:0]     ix;

   assign found = |eq_v;
   assign drain = |drain_v;
   assign full  = (used_ff >= USED_W'(LEVELS));

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      localparam int PI = (i == 0) ? 0 : i - 1;
      localparam int NI = (i == LEVELS - 1) ? i : i + 1;
      assign valid_v[i] = (USED_W'(i) < used_ff);
      plob_cell #(
         .QTY_W      (QTY_W),
         .CNT_W      (CNT_W),
         .DESCENDING (DESCENDING)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .valid_i    (valid_v[i]),
         .found_i    (found),
         .full_i     (full),
         .drain_i    (drain),
         .at_prev_i  ((i == 0) ? 1'b0 : at_v[PI]),
         .prev_price (price_a[PI]),
         .prev_qty   (qty_a[PI]),
         .prev_cnt   (cnt_a[PI]),
         .next_price (price_a[NI]),
         .next_qty   (qty_a[NI]),
         .next_cnt   (cnt_a[NI]),
         .price_o    (price_a[i]),
         .qty_o      (qty_a[i]),
         .cnt_o      (cnt_a[i]),
         .eq_o       (eq_v[i]),
         .at_o       (at_v[i]),
         .drain_o    (drain_v[i])
      );
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.op == OP_INSERT && !found && !full) begin
         used_in = used_ff + USED_W'(1);
      end else if (cmd.op == OP_REMOVE && found && drain) begin
         used_in = used_ff - USED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign stat.found = found;
   assign stat.full  = full;

   assign ix        = RW'(row_idx);
   assign row_valid = (ix < RW'(used_ff));
   assign row_price = price_a[ix[LVL_W-1:0]];
   assign row_qty   = qty_a[ix[LVL_W-1:0]];
   assign row_cnt   = cnt_a[ix[LVL_W-1:0]];

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(LEVELS))
      else $error("level count beyond table size");

endmodule

@@ hdl/price_level_order_book.sv @@
`timescale 1ns / 1ps
// An accepted item passes the order table read, the level update pass and
// then emits rows for bid then ask, rows per side being the depth register
// clamped to 1..DEPTH, one row per cycle while the output stage is free. No
// new item is taken until the last row of the previous one has been loaded.
// Reset (synchronous, active high) clears the book and counters, then runs
// a clearing pass over every order table slot; no item is accepted during
// it (configuration writes are taken).
module price_level_order_book
   import plob_pkg::*;
#(
   parameter int ORDER_SLOTS = 1024,
   parameter int LEVELS      = 16,
   parameter int DEPTH       = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_item_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int ID_W   = $clog2(ORDER_SLOTS);
   localparam int QTY_W  = 32 + ID_W;
   localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
   localparam int MOD_W  = ID_W + 10;
   localparam int QSAT_W = QTY_W + ROW_AMOUNT_W;
   localparam int CSAT_W = CNT_W + ROW_ORDERS_W;
   localparam int RCP_SH = 20;
   localparam int RCP    = ((1 << RCP_SH) + ORDER_SLOTS - 1) / ORDER_SLOTS;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   logic [ID_W-1:0]        clr_ff;
   logic [CSR_W-1:0]       depth_ff;
   req_item_type           item_ff;
   logic [ID_W-1:0]        id_ff;
   logic [1:0]             outcome_ff;
   logic [31:0]            trade_price_ff;
   logic [63:0]            volume_ff;
   logic                   trade_side_ff;
   logic                   side_ff;
   logic [ROW_LEVEL_W-1:0] row_ff;
   logic                   rsp_valid_ff;
   rsp_item_type           rsp_ff;

   // Order table port signals
   logic                   ram_we;
   logic [ID_W-1:0]        ram_waddr;
   order_entry_type        ram_wdata;
   order_entry_type        ram_rdata;
   logic [ID_W-1:0]        id_idx;
   logic [MOD_W-1:0]       id_rem;
   logic [RCP_SH+9:0]      id_prod;
   logic [9:0]             id_quo;

   level_cmd_type          cmd_bid, cmd_ask;
   level_stat_type         stat_bid, stat_ask;
   logic                   rv_bid, rv_ask;
   logic [31:0]            rp_bid, rp_ask;
   logic [QTY_W-1:0]       rq_bid, rq_ask;
   logic [CNT_W-1:0]       rc_bid, rc_ask;

   logic                   accept;
   logic                   rsp_load;
   logic                   is_insert, drop;
   logic [ROW_LEVEL_W-1:0] rows_eff;
   logic [ROW_LEVEL_W:0]   depth_lim;
   logic                   last_row;
   logic [64:0]            vol_sum;
   rsp_item_type           row_next;
   logic                   row_live;
   logic [31:0]            row_p;
   logic [QSAT_W-1:0]      row_q;
   logic [CSAT_W-1:0]      row_c;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Fold the order id into the table range: the reciprocal product gives
   // the exact quotient for every 10-bit id, then subtract quotient * slots
   assign id_prod = (RCP_SH + 10)'(req_data.book_id) * (RCP_SH + 10)'(RCP);
   assign id_quo  = id_prod[RCP_SH+9:RCP_SH];
   assign id_rem  = MOD_W'(req_data.book_id) - MOD_W'(id_quo) * MOD_W'(ORDER_SLOTS);
   assign id_idx  = id_rem[ID_W-1:0];

   plob_ram #(
      .WIDTH ($bits(order_entry_type)),
      .DEPTH (ORDER_SLOTS)
   ) u_orders (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (id_idx),
      .rdata (ram_rdata)
   );

   assign is_insert = (item_ff.action == ACT_ADD) || (item_ff.action == ACT_MODIFY);
   assign drop      = item_ff.side ? (!stat_ask.found && stat_ask.full)
                                   : (!stat_bid.found && stat_bid.full);

   // Level commands: remove the old order in READ, add the new one in UPDATE
   always_comb begin
      cmd_bid = '{op: OP_NOP, price: '0, amount: '0};
      cmd_ask = '{op: OP_NOP, price: '0, amount: '0};
      if (state_ff == ST_READ && item_ff.action != ACT_TRADE && ram_rdata.live) begin
         if (ram_rdata.on_ask) begin
            cmd_ask = '{op: OP_REMOVE, price: ram_rdata.price, amount: ram_rdata.qty};
         end else begin
            cmd_bid = '{op: OP_REMOVE, price: ram_rdata.price, amount: ram_rdata.qty};
         end
      end else if (state_ff == ST_UPDATE && is_insert) begin
         if (item_ff.side) begin
            cmd_ask = '{op: OP_INSERT, price: item_ff.price, amount: item_ff.amount};
         end else begin
            cmd_bid = '{op: OP_INSERT, price: item_ff.price, amount: item_ff.amount};
         end
      end
   end

   // Order table write: clearing pass, or the item's entry in UPDATE (not live after a cancel or a drop)
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = id_ff;
      ram_wdata = '{live: 1'b0, on_ask: item_ff.side, price: item_ff.price,
                    qty: item_ff.amount};
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
      end else if (state_ff == ST_UPDATE && item_ff.action != ACT_TRADE) begin
         ram_we         = 1'b1;
         ram_wdata.live = is_insert && !drop;
      end
   end

   plob_side #(
      .LEVELS (LEVELS), .QTY_W (QTY_W), .CNT_W (CNT_W), .DESCENDING (1'b1)
   ) u_bid (
      .clock (clock), .reset (reset), .cmd (cmd_bid), .stat (stat_bid),
      .row_idx (row_ff), .row_valid (rv_bid), .row_price (rp_bid),
      .row_qty (rq_bid), .row_cnt (rc_bid)
   );

   plob_side #(
      .LEVELS (LEVELS), .QTY_W (QTY_W), .CNT_W (CNT_W), .DESCENDING (1'b0)
   ) u_ask (
      .clock (clock), .reset (reset), .cmd (cmd_ask), .stat (stat_ask),
      .row_idx (row_ff), .row_valid (rv_ask), .row_price (rp_ask),
      .row_qty (rq_ask), .row_cnt (rc_ask)
   );

   // Rows per side: zero reads as one, anything past DEPTH as DEPTH
   assign depth_lim = (ROW_LEVEL_W + 1)'(DEPTH);
   always_comb begin
      if (depth_ff == '0) begin
         rows_eff = ROW_LEVEL_W'(1);
      end else if ({1'b0, depth_ff} > depth_lim) begin
         rows_eff = depth_lim[ROW_LEVEL_W-1:0];
      end else begin
         rows_eff = depth_ff;
      end
   end

   assign last_row = side_ff && (row_ff == rows_eff - ROW_LEVEL_W'(1));
   assign vol_sum  = {1'b0, volume_ff} + 65'(item_ff.amount);

   // load a new row whenever the output stage is free
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // Build the next depth row, zero past the live levels, sums saturated
   always_comb begin
      row_live = side_ff ? rv_ask : rv_bid;
      row_p    = row_live ? (side_ff ? rp_ask : rp_bid) : '0;
      row_q    = row_live ? QSAT_W'(side_ff ? rq_ask : rq_bid) : '0;
      row_c    = row_live ? CSAT_W'(side_ff ? rc_ask : rc_bid) : '0;
      row_next.echo_seq      = item_ff.seq;
      row_next.traded_price  = trade_price_ff;
      row_next.traded_volume = volume_ff;
      row_next.aggressor     = trade_side_ff;
      row_next.outcome       = outcome_ff;
      row_next.row_side      = side_ff;
      row_next.row_level     = row_ff;
      row_next.row_price     = row_p;
      row_next.row_amount    = (row_q > QSAT_W'({ROW_AMOUNT_W{1'b1}}))
                               ? {ROW_AMOUNT_W{1'b1}} : row_q[ROW_AMOUNT_W-1:0];
      row_next.row_orders    = (row_c > CSAT_W'({ROW_ORDERS_W{1'b1}}))
                               ? {ROW_ORDERS_W{1'b1}} : row_c[ROW_ORDERS_W-1:0];
      row_next.last_row      = last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         depth_ff       <= CSR_W'(1);
         outcome_ff     <= OUT_OK;
         trade_price_ff <= '0;
         volume_ff      <= '0;
         trade_side_ff  <= 1'b0;
         side_ff        <= 1'b0;
         row_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // take the register whenever written
         if (csr_we) begin
            depth_ff <= csr_wdata;
         end
         // hold a row until taken, then drop it unless a new one loads
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ID_W'(1);
               if (clr_ff == ID_W'(ORDER_SLOTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  item_ff  <= req_data;
                  id_ff    <= id_idx;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               // old entry is out of the table: flag a missing cancel or modify target
               outcome_ff <= ((item_ff.action == ACT_CANCEL ||
                               item_ff.action == ACT_MODIFY) && !ram_rdata.live)
                             ? OUT_NOTFOUND : OUT_OK;
               state_ff   <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (is_insert && drop) begin
                  outcome_ff <= OUT_FULL;
               end
               if (item_ff.action == ACT_TRADE) begin
                  trade_price_ff <= item_ff.price;
                  trade_side_ff  <= item_ff.side;
                  volume_ff      <= vol_sum[64] ? '1 : vol_sum[63:0];
               end
               side_ff  <= 1'b0;
               row_ff   <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               // advance one row whenever the output stage is free
               if (rsp_load) begin
                  rsp_ff <= row_next;
                  if (last_row) begin
                     state_ff <= ST_IDLE;
                  end else if (row_ff == rows_eff - ROW_LEVEL_W'(1)) begin
                     side_ff <= 1'b1;
                     row_ff  <= '0;
                  end else begin
                     row_ff <= row_ff + ROW_LEVEL_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second item taken while one is in work");

   a_last_on_ask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_row |-> rsp_data.row_side)
      else $error("final row not on the ask side");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.row_level < rows_eff))
      else $error("row level beyond reported depth");

endmodule

@@ dv/price_level_order_book_tb.sv @@
`timescale 1ns / 1ps
module price_level_order_book_tb;
   import plob_pkg::*;

   localparam int SLOTS     = 1024;
   localparam int NLEVELS   = 16;
   localparam int MAX_DEPTH = 10;
   localparam logic [41:0] AMT_SAT = {42{1'b1}};
   localparam logic [10:0] CNT_SAT = {11{1'b1}};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_we = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // idle odds, in percent, for each side of the handshake
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned fail_count = 0;

   rsp_item_type book_rows_due[$];

   // shadow of the book
   logic [3:0]  depth_rows_q;
   bit          ord_live [SLOTS];
   bit          ord_ask  [SLOTS];
   logic [31:0] ord_price[SLOTS];
   logic [31:0] ord_qty  [SLOTS];
   logic [31:0] lvl_price[2][NLEVELS];
   logic [63:0] lvl_qty  [2][NLEVELS];
   int unsigned lvl_cnt  [2][NLEVELS];
   int unsigned lvl_used [2];
   logic [31:0] last_seq, last_trade_price;
   logic [63:0] volume_sum;
   logic        last_aggressor;

   price_level_order_book dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // find a price level; pos is where it lives or where it would go
   function automatic bit find_level(int s, logic [31:0] p, output int pos);
      int n;
      n = lvl_used[s];
      for (int i = 0; i < n; i++) begin
         if (lvl_price[s][i] == p) begin
            pos = i;
            return 1;
         end
         if (s == 0 ? (p > lvl_price[s][i]) : (p < lvl_price[s][i])) begin
            pos = i;
            return 0;
         end
      end
      pos = n;
      return 0;
   endfunction

   function automatic bit pull_order(int id);
      int s, pos;
      if (!ord_live[id]) return 0;
      s = ord_ask[id];
      if (find_level(s, ord_price[id], pos)) begin
         lvl_qty[s][pos] = (lvl_qty[s][pos] >= ord_qty[id]) ?
                           lvl_qty[s][pos] - ord_qty[id] : 64'd0;
         if (lvl_cnt[s][pos] > 0) lvl_cnt[s][pos]--;
         if (lvl_cnt[s][pos] == 0) begin
            for (int i = pos; i + 1 < lvl_used[s]; i++) begin
               lvl_price[s][i] = lvl_price[s][i+1];
               lvl_qty[s][i]   = lvl_qty[s][i+1];
               lvl_cnt[s][i]   = lvl_cnt[s][i+1];
            end
            lvl_used[s]--;
         end
      end
      ord_live[id] = 0;
      return 1;
   endfunction

   function automatic bit rest_order(int id, int s, logic [31:0] p, logic [31:0] a);
      int pos;
      if (find_level(s, p, pos)) begin
         lvl_qty[s][pos] += a;
         lvl_cnt[s][pos]++;
      end else begin
         if (lvl_used[s] >= NLEVELS) return 0;
         for (int i = lvl_used[s]; i > pos; i--) begin
            lvl_price[s][i] = lvl_price[s][i-1];
            lvl_qty[s][i]   = lvl_qty[s][i-1];
            lvl_cnt[s][i]   = lvl_cnt[s][i-1];
         end
         lvl_price[s][pos] = p;
         lvl_qty[s][pos]   = 64'(a);
         lvl_cnt[s][pos]   = 1;
         lvl_used[s]++;
      end
      ord_live[id]  = 1;
      ord_ask[id]   = s[0];
      ord_price[id] = p;
      ord_qty[id]   = a;
      return 1;
   endfunction

   function automatic int rows_per_side();
      int r;
      r = depth_rows_q;
      if (r < 1) r = 1;
      if (r > MAX_DEPTH) r = MAX_DEPTH;
      return r;
   endfunction

   // apply one event to the shadow book and queue the depth rows it yields
   function automatic void apply_event(req_item_type it);
      outcome_type oc;
      int rows;
      rsp_item_type row;
      oc = OUT_OK;
      last_seq = it.seq;
      case (action_type'(it.action))
         ACT_ADD: begin
            void'(pull_order(int'(it.book_id)));
            if (!rest_order(int'(it.book_id), int'(it.side), it.price, it.amount))
               oc = OUT_FULL;
         end
         ACT_CANCEL: begin
            if (!pull_order(int'(it.book_id))) oc = OUT_NOTFOUND;
         end
         ACT_MODIFY: begin
            if (!pull_order(int'(it.book_id))) oc = OUT_NOTFOUND;
            if (!rest_order(int'(it.book_id), int'(it.side), it.price, it.amount))
               oc = OUT_FULL;
         end
         default: begin
            last_trade_price = it.price;
            volume_sum = (volume_sum > 64'hFFFF_FFFF_FFFF_FFFF - it.amount) ?
                         64'hFFFF_FFFF_FFFF_FFFF : volume_sum + it.amount;
            last_aggressor = it.side;
         end
      endcase
      rows = rows_per_side();
      for (int s = 0; s < 2; s++) begin
         for (int k = 0; k < rows; k++) begin
            row = '0;
            row.echo_seq      = last_seq;
            row.traded_price  = last_trade_price;
            row.traded_volume = volume_sum;
            row.aggressor     = last_aggressor;
            row.outcome       = oc;
            row.row_side      = 1'(s);
            row.row_level     = 4'(k);
            if (k < lvl_used[s]) begin
               row.row_price  = lvl_price[s][k];
               row.row_amount = (lvl_qty[s][k] > AMT_SAT) ? AMT_SAT : 42'(lvl_qty[s][k]);
               row.row_orders = (lvl_cnt[s][k] > CNT_SAT) ? CNT_SAT : 11'(lvl_cnt[s][k]);
            end
            row.last_row = (s == 1 && k + 1 == rows);
            book_rows_due = {book_rows_due, row};
         end
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fail_count++;
      $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
   endtask

   // check each accepted row against the oldest queued one
   always @(posedge clock) begin
      rsp_item_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (book_rows_due.size() == 0) begin
            report_mismatch("unexpected row seq", rsp_data.echo_seq, 0);
         end else begin
            w = book_rows_due.pop_front();
            if (rsp_data.echo_seq !== w.echo_seq)
               report_mismatch("echo_seq", rsp_data.echo_seq, w.echo_seq);
            if (rsp_data.traded_price !== w.traded_price)
               report_mismatch("traded_price", rsp_data.traded_price, w.traded_price);
            if (rsp_data.traded_volume !== w.traded_volume)
               report_mismatch("traded_volume", rsp_data.traded_volume, w.traded_volume);
            if (rsp_data.aggressor !== w.aggressor)
               report_mismatch("aggressor", rsp_data.aggressor, w.aggressor);
            if (rsp_data.outcome !== w.outcome)
               report_mismatch("outcome", rsp_data.outcome, w.outcome);
            if (rsp_data.row_side !== w.row_side)
               report_mismatch("row_side", rsp_data.row_side, w.row_side);
            if (rsp_data.row_level !== w.row_level)
               report_mismatch("row_level", rsp_data.row_level, w.row_level);
            if (rsp_data.row_price !== w.row_price)
               report_mismatch("row_price", rsp_data.row_price, w.row_price);
            if (rsp_data.row_amount !== w.row_amount)
               report_mismatch("row_amount", rsp_data.row_amount, w.row_amount);
            if (rsp_data.row_orders !== w.row_orders)
               report_mismatch("row_orders", rsp_data.row_orders, w.row_orders);
            if (rsp_data.last_row !== w.last_row)
               report_mismatch("last_row", rsp_data.last_row, w.last_row);
         end
      end
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // send one event: idle at random first, then hold valid until taken
   task automatic send_event(action_type act, logic [9:0] id, logic side,
                             logic [31:0] price, logic [31:0] amount);
      req_item_type it;
      it.action = act;
      it.seq = $urandom;
      it.book_id = id;
      it.side = side;
      it.price = price;
      it.amount = amount;
      @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      apply_event(it);
      req_valid <= 1'b0;
   endtask

   // drain all rows, then let the block settle before touching the register
   task automatic wait_drained();
      while (book_rows_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_depth(logic [3:0] v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      depth_rows_q = v;
   endtask

   // directed: extremes, every action, each special case
   task automatic test_directed();
      set_depth(4'd3);
      send_event(ACT_ADD, 10'd0, 1'b0, 32'd100, 32'd5);
      send_event(ACT_ADD, 10'd1023, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_event(ACT_ADD, 10'd2, 1'b0, 32'd100, 32'hFFFF_FFFF);
      send_event(ACT_ADD, 10'd3, 1'b1, 32'd0, 32'd0);
      // add of a live id replaces it
      send_event(ACT_ADD, 10'd0, 1'b1, 32'd200, 32'd7);
      send_event(ACT_CANCEL, 10'd500, 1'b0, 32'd0, 32'd0);
      send_event(ACT_MODIFY, 10'd501, 1'b0, 32'd90, 32'd3);
      send_event(ACT_MODIFY, 10'd2, 1'b1, 32'd150, 32'd4);
      send_event(ACT_CANCEL, 10'd1023, 1'b0, 32'd0, 32'd0);
      send_event(ACT_TRADE, 10'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_event(ACT_TRADE, 10'h3FF, 1'b0, 32'd123, 32'd1);
      // fill the bid side, then overflow it
      for (int i = 0; i < NLEVELS + 1; i++)
         send_event(ACT_ADD, 10'(100 + i), 1'b0, 32'(1000 + i), 32'd1);
      // modify on a full side: the old level is removed, so the new price fits
      send_event(ACT_MODIFY, 10'd100, 1'b0, 32'd5, 32'd1);
      // clear the book again
      wait_drained();
      for (int id = 0; id < SLOTS; id++)
         if (ord_live[id]) send_event(ACT_CANCEL, 10'(id), 1'b0, 32'd0, 32'd0);
   endtask

   // large trades push the volume well past 32 bits
   task automatic test_volume_saturation();
      for (int i = 0; i < 8; i++)
         send_event(ACT_TRADE, 10'($urandom), 1'($urandom), $urandom, 32'hFFFF_FFFF);
   endtask

   // random: mostly live-book traffic on a small id and price space
   task automatic test_random(int n);
      int r;
      logic [9:0] id;
      for (int i = 0; i < n; i++) begin
         r  = $urandom_range(99);
         id = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(40));
         if (r < 45)
            send_event(ACT_ADD, id, 1'($urandom), $urandom_range(60) + 32'd1000,
                       ($urandom_range(9) == 0) ? $urandom : $urandom_range(1000));
         else if (r < 65)
            send_event(ACT_CANCEL, id, 1'($urandom), $urandom, $urandom);
         else if (r < 85)
            send_event(ACT_MODIFY, id, 1'($urandom), $urandom_range(60) + 32'd1000,
                       $urandom_range(1000));
         else
            send_event(ACT_TRADE, id, 1'($urandom), $urandom, $urandom);
         // hold off once per phase until all queued rows are drained
         if (i == n / 2) wait_drained();
      end
   endtask

   initial begin
      depth_rows_q = 4'd1;
      lvl_used[0] = 0;
      lvl_used[1] = 0;
      last_seq = '0;
      last_trade_price = '0;
      volume_sum = '0;
      last_aggressor = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // skip the clearing pass: first send waits on ready anyway
      send_idle_pct = 7;
      recv_idle_pct = 65;
      test_directed();
      set_depth(4'd10);
      test_random(40);
      set_depth(4'd0);
      send_idle_pct = 65;
      recv_idle_pct = 7;
      test_random(40);
      set_depth(4'd15);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_volume_saturation();
      test_random(20);
      set_depth(4'd1);
      test_random(15);
      wait_drained();
      if (fail_count == 0) begin
         $display("price_level_order_book regression: pass");
      end else begin
         $display("price_level_order_book regression: fail");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("price_level_order_book regression: fail");
      $finish;
   end

endmodule
